FILE: rtl/core/oblique_step_retraction_unit_assert.svh
// ----------------------------------------------------------------------------
// oblique_step_retraction_unit_assert.svh
// Assertion macros for the oblique step retraction unit.
// ----------------------------------------------------------------------------
`ifndef OBLIQUE_STEP_RETRACTION_UNIT_ASSERT_SVH
`define OBLIQUE_STEP_RETRACTION_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define OSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OSR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OSR_ASSERT(label, prop, msg)
`define OSR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/core/osr_pkg.sv
// ----------------------------------------------------------------------------
// osr_pkg
// Shared constants and types of the oblique step retraction unit.
// ----------------------------------------------------------------------------
package osr_pkg;

    localparam int COLUMN_LEN_MAX = 64;
    localparam int ADDR_W         = $clog2(COLUMN_LEN_MAX);
    localparam int COUNT_W        = $clog2(COLUMN_LEN_MAX + 1);
    localparam int ELEM_W         = 32;
    localparam int STEP_W         = 31;
    localparam int CNT_W          = 6;

    localparam logic [STEP_W-1:0] STEP_RESET   = 31'd268435456;
    localparam logic [CNT_W-1:0]  MUL_LAST     = 6'd30;
    localparam logic [CNT_W-1:0]  SQ_LAST      = 6'd31;
    localparam logic [CNT_W-1:0]  ROOT_LAST    = 6'd31;
    localparam logic [CNT_W-1:0]  DIV_LAST     = 6'd55;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SAT,
        S_SQ,
        S_ACC,
        S_ROOT,
        S_RD,
        S_LOAD,
        S_DIV,
        S_OUT
    } state_t;

endpackage

FILE: rtl/core/oblique_step_retraction_unit.sv
// ----------------------------------------------------------------------------
// oblique_step_retraction_unit
// Steps a column element by element, then emits it scaled to unit norm.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_ready  | point_elem, dir_elem, last_in_column
//  out      | out_valid / out_ready| out_elem, last_of_column, zero_norm
//  cfg      | cfg_we               | cfg_wdata (step_size)
//
//  Load: per word, shift-add step multiply, saturate, square and accumulate.
//  Close of column: bit-pair square root, then per emitted word a RAM read
//  and a restoring divide (skipped on zero norm), plus any output stall.
//  Reset clears control state; no clearing pass. Words are taken only in idle;
//  the output register lets the next word in while the last result waits.
// ----------------------------------------------------------------------------
`include "oblique_step_retraction_unit_assert.svh"

module oblique_step_retraction_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  point_elem,
    input  logic signed [31:0]  dir_elem,
    input  logic                last_in_column,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_elem,
    output logic                last_of_column,
    output logic                zero_norm,
    input  logic                cfg_we,
    input  logic [30:0]         cfg_wdata
);

    osr_pkg::state_t state_reg, state_next;

    logic [osr_pkg::STEP_W-1:0]  step_reg;
    logic [osr_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [osr_pkg::COUNT_W-1:0] k_reg, k_next;
    logic [osr_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [63:0] rbit_reg, rbit_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] norm_reg, norm_next;
    logic        zero_reg, zero_next;
    logic        last_reg, last_next;
    logic        sign_reg, sign_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_elem_reg, out_elem_next;
    logic        out_last_reg, out_last_next;
    logic        out_zero_reg, out_zero_next;

    logic                       ram_we;
    logic [31:0]                ram_wdata;
    logic [31:0]                ram_rdata;

    logic [35:0] t_shift;
    logic [31:0] s_val;
    logic [31:0] s_mag;
    logic [64:0] root_try;
    logic [32:0] div_try;
    logic [31:0] quot_res;
    logic        out_free;

    osr_ram #(
        .WIDTH (osr_pkg::ELEM_W),
        .DEPTH (osr_pkg::COLUMN_LEN_MAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[osr_pkg::ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (k_reg[osr_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // saturate step result, floor shift by 28
    always_comb
    begin
        t_shift = acc_reg[63:28];
        if ((t_shift[35:31] != 5'b00000) && (t_shift[35:31] != 5'b11111))
        begin
            s_val = t_shift[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            s_val = t_shift[31:0];
        end
        s_mag = s_val[31] ? (32'd0 - s_val) : s_val;
    end

    // saturated signed quotient
    always_comb
    begin
        if (sign_reg)
        begin
            if (acc_reg[55:0] > 56'h0000_0080_0000_00)
            begin
                quot_res = 32'h8000_0000;
            end
            else
            begin
                quot_res = 32'd0 - acc_reg[31:0];
            end
        end
        else
        begin
            if (acc_reg[55:0] > 56'h0000_007F_FFFF_FF)
            begin
                quot_res = 32'h7FFF_FFFF;
            end
            else
            begin
                quot_res = acc_reg[31:0];
            end
        end
    end

    assign root_try = {1'b0, mcand_reg} + {1'b0, rbit_reg};
    assign div_try  = {rem_reg[31:0], mcand_reg[55]};
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= osr_pkg::S_IDLE;
            step_reg      <= osr_pkg::STEP_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        rbit_reg     <= rbit_next;
        mplier_reg   <= mplier_next;
        rem_reg      <= rem_next;
        norm_reg     <= norm_next;
        zero_reg     <= zero_next;
        last_reg     <= last_next;
        sign_reg     <= sign_next;
        out_elem_reg <= out_elem_next;
        out_last_reg <= out_last_next;
        out_zero_reg <= out_zero_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        rbit_next      = rbit_reg;
        mplier_next    = mplier_reg;
        rem_next       = rem_reg;
        norm_next      = norm_reg;
        zero_next      = zero_reg;
        last_next      = last_reg;
        sign_next      = sign_reg;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        out_zero_next  = out_zero_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = s_val;

        case (state_reg)
            osr_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next = last_in_column;
                    if (count_reg < osr_pkg::COUNT_W'(osr_pkg::COLUMN_LEN_MAX))
                    begin
                        acc_next    = {{4{point_elem[31]}}, point_elem, 28'h800_0000};
                        mcand_next  = {{32{dir_elem[31]}}, dir_elem};
                        mplier_next = {1'b0, step_reg};
                        cnt_next    = '0;
                        state_next  = osr_pkg::S_MUL;
                    end
                    else if (last_in_column)
                    begin
                        acc_next   = sum_reg;
                        mcand_next = '0;
                        rbit_next  = 64'h4000_0000_0000_0000;
                        cnt_next   = '0;
                        state_next = osr_pkg::S_ROOT;
                    end
                end
            end

            osr_pkg::S_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == osr_pkg::MUL_LAST)
                begin
                    state_next = osr_pkg::S_SAT;
                end
            end

            osr_pkg::S_SAT:
            begin
                ram_we      = 1'b1;
                acc_next    = '0;
                mcand_next  = {32'd0, s_mag};
                mplier_next = s_mag;
                cnt_next    = '0;
                state_next  = osr_pkg::S_SQ;
            end

            osr_pkg::S_SQ:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == osr_pkg::SQ_LAST)
                begin
                    state_next = osr_pkg::S_ACC;
                end
            end

            osr_pkg::S_ACC:
            begin
                sum_next   = sum_reg + (acc_reg >> 8);
                count_next = count_reg + 1'b1;
                if (last_reg)
                begin
                    acc_next   = sum_next;
                    mcand_next = '0;
                    rbit_next  = 64'h4000_0000_0000_0000;
                    cnt_next   = '0;
                    state_next = osr_pkg::S_ROOT;
                end
                else
                begin
                    state_next = osr_pkg::S_IDLE;
                end
            end

            // bit-pair square root: acc = remainder, mcand = root
            osr_pkg::S_ROOT:
            begin
                if ({1'b0, acc_reg} >= root_try)
                begin
                    acc_next   = acc_reg - root_try[63:0];
                    mcand_next = (mcand_reg >> 1) + rbit_reg;
                end
                else
                begin
                    mcand_next = mcand_reg >> 1;
                end
                rbit_next = rbit_reg >> 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == osr_pkg::ROOT_LAST)
                begin
                    norm_next  = mcand_next[31:0];
                    zero_next  = (mcand_next[31:0] == 32'd0);
                    k_next     = '0;
                    state_next = osr_pkg::S_RD;
                end
            end

            osr_pkg::S_RD:
            begin
                state_next = osr_pkg::S_LOAD;
            end

            osr_pkg::S_LOAD:
            begin
                sign_next  = ram_rdata[31];
                mcand_next = {8'd0, (ram_rdata[31] ? (32'd0 - ram_rdata) : ram_rdata), 24'd0};
                acc_next   = '0;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = zero_reg ? osr_pkg::S_OUT : osr_pkg::S_DIV;
            end

            // restoring divide: mcand = dividend, acc = quotient
            osr_pkg::S_DIV:
            begin
                mcand_next = mcand_reg << 1;
                if (div_try >= {1'b0, norm_reg})
                begin
                    rem_next = div_try - {1'b0, norm_reg};
                    acc_next = {acc_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = div_try;
                    acc_next = {acc_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == osr_pkg::DIV_LAST)
                begin
                    state_next = osr_pkg::S_OUT;
                end
            end

            osr_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_elem_next  = quot_res;
                    out_zero_next  = zero_reg;
                    out_last_next  = (k_reg + 1'b1 == count_reg);
                    k_next         = k_reg + 1'b1;
                    if (k_reg + 1'b1 == count_reg)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                        state_next = osr_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = osr_pkg::S_RD;
                    end
                end
            end

            default:
            begin
                state_next = osr_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign out_elem       = out_elem_reg;
    assign last_of_column = out_last_reg;
    assign zero_norm      = out_zero_reg;

    `OSR_ASSERT(a_zero_out, (out_valid && zero_norm) |-> (out_elem == 32'd0), "zero norm word nonzero")
    `OSR_ASSERT(a_count_max, count_reg <= osr_pkg::COUNT_W'(osr_pkg::COLUMN_LEN_MAX), "count overflow")
    `OSR_ASSERT(a_rd_range, (state_reg == osr_pkg::S_RD) |-> (k_reg < count_reg), "read past column")
    `OSR_ASSERT(a_close_clear, (state_reg == osr_pkg::S_OUT && out_free && out_last_next) |=> (count_reg == '0 && sum_reg == '0), "column not cleared")

endmodule

FILE: rtl/core/osr_ram.sv
// ----------------------------------------------------------------------------
// osr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module osr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: bench/oblique_step_retraction_unit_tb.sv
// ----------------------------------------------------------------------------
// oblique_step_retraction_unit_tb
// Self-checking bench: columns of point/direction words are pushed through the
// block under several step sizes; a behavioral copy of the column retraction
// predicts every normalized word, which the monitor checks in order.
// ----------------------------------------------------------------------------
module oblique_step_retraction_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 3000000;

    typedef struct {
        logic signed [31:0] point;
        logic signed [31:0] dir;
        logic               last;
    } in_word_t;

    typedef struct {
        logic signed [31:0] elem;
        logic               last;
        logic               zero;
    } out_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic signed [31:0] point_elem = '0;
    logic signed [31:0] dir_elem = '0;
    logic              last_in_column = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic signed [31:0] out_elem;
    logic              last_of_column;
    logic              zero_norm;
    logic              cfg_we = 1'b0;
    logic [30:0]       cfg_wdata = '0;

    in_word_t  word_q[$];
    out_word_t norm_q[$];

    logic [30:0]        step_len = osr_pkg::STEP_RESET;
    logic signed [31:0] col_elems[osr_pkg::COLUMN_LEN_MAX];
    logic [63:0]        sq_total = '0;
    int                 col_cnt = 0;
    int                 errs = 0;
    int                 cycles = 0;

    oblique_step_retraction_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .point_elem     (point_elem),
        .dir_elem       (dir_elem),
        .last_in_column (last_in_column),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_elem       (out_elem),
        .last_of_column (last_of_column),
        .zero_norm      (zero_norm),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic retract_word(in_word_t w);
        longint            total;
        longint            s;
        logic signed [31:0] sv;
        longint            sq;
        logic [63:0]       norm;
        logic [63:0]       mag;
        logic [63:0]       q;
        out_word_t         o;
        if (col_cnt < osr_pkg::COLUMN_LEN_MAX)
        begin
            total = longint'(w.point) * 64'sd268435456
                  + longint'({1'b0, step_len}) * longint'(w.dir) + 64'sd134217728;
            s = total >>> 28;
            if (s > 64'sd2147483647)
                sv = 32'sh7fffffff;
            else if (s < -64'sd2147483648)
                sv = 32'sh80000000;
            else
                sv = s[31:0];
            sq = longint'(sv) * longint'(sv);
            col_elems[col_cnt] = sv;
            sq_total = sq_total + (64'(sq) >> 8);
            col_cnt++;
        end
        if (!w.last)
            return;
        norm = int_sqrt(sq_total);
        for (int k = 0; k < col_cnt; k++)
        begin
            o.elem = '0;
            if (norm != 0)
            begin
                mag = (col_elems[k] < 0) ? 64'(-longint'(col_elems[k]))
                                         : 64'(longint'(col_elems[k]));
                q = (mag << 24) / norm;
                if (col_elems[k] < 0)
                    o.elem = (q > 64'd2147483648) ? 32'sh80000000 : 32'(-longint'(q));
                else
                    o.elem = (q > 64'd2147483647) ? 32'sh7fffffff : q[31:0];
            end
            o.last = (k + 1 == col_cnt);
            o.zero = (norm == 0);
            norm_q.push_back(o);
        end
        sq_total = '0;
        col_cnt = 0;
    endtask

    // driver
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic     busy;
        in_word_t w;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                w.point = point_elem;
                w.dir = dir_elem;
                w.last = last_in_column;
                retract_word(w);
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_q.size() > 0)
                begin
                    w = word_q.pop_front();
                    point_elem <= w.point;
                    dir_elem <= w.dir;
                    last_in_column <= w.last;
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and monitor
    int rx_cycles = 0;
    int hold_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            rx_cycles++;
            if (out_valid && out_ready)
            begin
                if (norm_q.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected word: elem=%0d last=%0b zero=%0b",
                                 out_elem, last_of_column, zero_norm);
                end
                else
                begin
                    e = norm_q.pop_front();
                    if (out_elem !== e.elem || last_of_column !== e.last ||
                        zero_norm !== e.zero)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("mismatch: exp elem=%0d last=%0b zero=%0b, got elem=%0d last=%0b zero=%0b",
                                     e.elem, e.last, e.zero,
                                     out_elem, last_of_column, zero_norm);
                    end
                end
            end
            if (rx_cycles == 20000)
                hold_left = 5000;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_cycles % 4000 < 1500)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) < 40);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [31:0] rand_val(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h3fffffff)) - 32'sh20000000);
            2: return 32'($signed($urandom_range(0, 30)) - 15);
            default: return ($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    task automatic add_column(int len, int pmode, int dmode);
        in_word_t w;
        for (int i = 0; i < len; i++)
        begin
            w.point = rand_val(pmode);
            w.dir = rand_val(dmode);
            w.last = (i == len - 1);
            word_q.push_back(w);
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (word_q.size() > 0 || in_valid || norm_q.size() > 0);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_step(logic [30:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        step_len = v;
        @(negedge clk);
    endtask

    initial
    begin
        in_word_t w;
        int       sent;
        int       len;
        logic [30:0] steps[4];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, saturation, zero norm, single word, overlong column
        write_step(31'h7fffffff);
        w.point = 32'sh7fffffff; w.dir = 32'sh7fffffff; w.last = 1'b0; word_q.push_back(w);
        w.point = 32'sh80000000; w.dir = 32'sh80000000; w.last = 1'b0; word_q.push_back(w);
        w.point = 32'sh7fffffff; w.dir = 32'sh80000000; w.last = 1'b1; word_q.push_back(w);
        w.point = 32'sh80000000; w.dir = 32'sh00000000; w.last = 1'b1; word_q.push_back(w);
        w.point = 32'sh00000001; w.dir = 32'sh00000000; w.last = 1'b0; word_q.push_back(w);
        w.point = -32'sd15;      w.dir = 32'sh00000000; w.last = 1'b1; word_q.push_back(w);
        w.point = 32'sh10000000; w.dir = 32'sh00000000; w.last = 1'b1; word_q.push_back(w);
        w.point = -32'sd16;      w.dir = 32'sh00000000; w.last = 1'b1; word_q.push_back(w);
        drain();
        write_step(31'd0);
        w.point = 32'sh12345678; w.dir = 32'sh7fffffff; w.last = 1'b1; word_q.push_back(w);
        w.point = 32'sh00000000; w.dir = 32'sh80000000; w.last = 1'b1; word_q.push_back(w);
        add_column(66, 1, 1);
        drain();

        steps[0] = osr_pkg::STEP_RESET;
        steps[1] = 31'h7fffffff;
        steps[2] = 31'd0;
        steps[3] = 31'($urandom());
        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_step(steps[ph]);
            while (sent < 62 * (ph + 1))
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64)
                                                   : $urandom_range(1, 8);
                if ($urandom_range(0, 9) == 0)
                    add_column(len, 2, 2);
                else
                    add_column(len, $urandom_range(0, 3), $urandom_range(0, 3));
                sent += len;
            end
            drain();
        end

        if (errs == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/osr_pkg.sv
rtl/core/osr_ram.sv
rtl/core/oblique_step_retraction_unit.sv
bench/oblique_step_retraction_unit_tb.sv
